// ===== sv/pgu_pkg.sv =====
// Shared constants, payload structs and the saturation helper for the
// particle gravity update pipeline. No dependencies.
`default_nettype none
package pgu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ALPHA_W   = 17;
  // quotient bits of the fade divide: alpha spans 0 .. 1.0 inclusive
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIV_STEPS = Q_W;

  typedef struct packed {
    logic [30:0] num;
    logic [30:0] den;
    logic        zero;
  } div_op_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] n;
    logic               keep;
  } kin_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/particle_gravity_update_top.sv =====
// Top level of the particle gravity update pipeline: config registers,
// valid tracking, kinematics, fade divider and result alignment.
// Depends on pgu_pkg, pgu_kin and pgu_div.
`default_nettype none
// One particle record enters per cycle while in_ready is high; its result
// leaves after the fade divider, which resolves one quotient bit per stage
// (17 stages) behind two stages of life decay and operand setup. in_ready
// is the ready output that holds back new records while the output stalls.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so backpressure stalls every stage in place and
// nothing is lost or repeated. gravity_accel and step_seconds (Q16.16)
// must be written while the pipeline is empty; step defaults to 1092
// (about 1/60 s). Dead or expiring particles pass position and velocity
// through unchanged with keep low; life and fade are still reported.
module particle_gravity_update_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic [30:0]        in_full_life,
  input  wire logic signed [31:0] in_life_left,
  input  wire logic [30:0]        in_decay_rate,
  input  wire logic               in_was_dead,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_new_pos_x,
  output logic signed [31:0]      out_new_pos_y,
  output logic signed [31:0]      out_new_vel_x,
  output logic signed [31:0]      out_new_vel_y,
  output logic signed [31:0]      out_old_pos_x,
  output logic signed [31:0]      out_old_pos_y,
  output logic signed [31:0]      out_new_life_left,
  output logic [16:0]             out_fade_alpha,
  output logic                    out_keep
);
  import pgu_pkg::*;

  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_STEP    = 1'b1;
  // total stages: two front stages, then one per quotient bit
  localparam int LAT = DIV_STEPS + 2;
  // kinematics finish at stage 4; hold them until the divider catches up
  localparam int DLY = LAT - 4;

  logic signed [31:0] gravity_r;
  logic [16:0]        step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= '0;
      step_r    <= 17'd1092;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY: gravity_r <= cfg_wdata;
        CFG_STEP:    step_r    <= cfg_wdata[16:0];
        default:     ;
      endcase
    end
  end

  // global advance: output register free or being drained
  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[LAT-1];

  div_op_t  div_op;
  kin_res_t kin_res;
  logic [16:0] alpha;

  pgu_kin u_kin (
    .clk        (clk),
    .en         (en),
    .gravity    (gravity_r),
    .step       (step_r),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .vel_x      (in_vel_x),
    .vel_y      (in_vel_y),
    .full_life  (in_full_life),
    .life_left  (in_life_left),
    .decay_rate (in_decay_rate),
    .was_dead   (in_was_dead),
    .div_op     (div_op),
    .kin_res    (kin_res)
  );

  pgu_div u_div (
    .clk   (clk),
    .en    (en),
    .op    (div_op),
    .alpha (alpha)
  );

  kin_res_t dly_r [DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DLY; k++) begin
        if (k == 0) begin
          dly_r[k] <= kin_res;
        end else begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
  end

  assign out_new_pos_x     = dly_r[DLY-1].nx;
  assign out_new_pos_y     = dly_r[DLY-1].ny;
  assign out_new_vel_x     = dly_r[DLY-1].nvx;
  assign out_new_vel_y     = dly_r[DLY-1].nvy;
  assign out_old_pos_x     = dly_r[DLY-1].px;
  assign out_old_pos_y     = dly_r[DLY-1].py;
  assign out_new_life_left = dly_r[DLY-1].n;
  assign out_keep          = dly_r[DLY-1].keep;
  assign out_fade_alpha    = alpha;

endmodule
`default_nettype wire

// ===== sv/pgu_kin.sv =====
// Life decay, gravity Euler step and fade-divide operand setup, four stages.
// Depends on pgu_pkg.
`default_nettype none
module pgu_kin (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] gravity,
  input  wire logic [16:0]        step,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic [30:0]        full_life,
  input  wire logic signed [31:0] life_left,
  input  wire logic [30:0]        decay_rate,
  input  wire logic               was_dead,
  output pgu_pkg::div_op_t        div_op,
  output pgu_pkg::kin_res_t       kin_res
);
  import pgu_pkg::*;

  logic signed [17:0] dt_s;
  assign dt_s = $signed({1'b0, step});

  // stage 1
  logic signed [31:0] px1_r, py1_r, vx1_r, vy1_r, n1_r;
  logic [30:0]        d1_r;
  logic               dead_in1_r;
  logic signed [49:0] gdt1_r, vxdt1_r;
  logic signed [31:0] n1_nxt;

  assign n1_nxt = sat32(64'(life_left) - 64'($signed({1'b0, decay_rate})));

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r      <= pos_x;
      py1_r      <= pos_y;
      vx1_r      <= vel_x;
      vy1_r      <= vel_y;
      d1_r       <= full_life;
      dead_in1_r <= was_dead;
      n1_r       <= n1_nxt;
      gdt1_r     <= gravity * dt_s;
      vxdt1_r    <= vel_x * dt_s;
    end
  end

  // stage 2: velocity, x position, keep, divide operands
  logic signed [31:0] px2_r, py2_r, vx2_r, nx2_r, nvy2_r, n2_r;
  logic               keep2_r;
  div_op_t            op2_r;
  logic               dead2;
  logic signed [31:0] nvy2_nxt, nx2_nxt;
  logic signed [33:0] two_n, dd, dmn;
  div_op_t            op2_nxt;

  assign dead2    = dead_in1_r | (n1_r <= 32'sd0);
  assign nvy2_nxt = sat32(64'(vy1_r) + 64'(gdt1_r >>> FRAC_BITS));
  assign nx2_nxt  = sat32(64'(px1_r) + 64'(vxdt1_r >>> FRAC_BITS));

  always_comb begin
    two_n = {n1_r[31], n1_r, 1'b0};
    dd    = $signed({3'b000, d1_r});
    dmn   = dd - 34'(n1_r);
    op2_nxt.den  = d1_r;
    op2_nxt.num  = '0;
    op2_nxt.zero = 1'b0;
    if (d1_r == '0) begin
      op2_nxt.zero = 1'b1;
    end else if (two_n < dd) begin
      if (two_n < 34'sd0) begin
        op2_nxt.zero = 1'b1;
      end else begin
        op2_nxt.num = two_n[30:0];
      end
    end else if (dmn < 34'sd0) begin
      op2_nxt.zero = 1'b1;
    end else begin
      op2_nxt.num = {dmn[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      vx2_r   <= vx1_r;
      n2_r    <= n1_r;
      keep2_r <= ~dead2;
      nvy2_r  <= dead2 ? vy1_r : nvy2_nxt;
      nx2_r   <= dead2 ? px1_r : nx2_nxt;
      op2_r   <= op2_nxt;
    end
  end

  assign div_op = op2_r;

  // stage 3: y displacement product from the updated velocity
  logic signed [31:0] px3_r, py3_r, vx3_r, nx3_r, nvy3_r, n3_r;
  logic               keep3_r;
  logic signed [49:0] vydt3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      vx3_r   <= vx2_r;
      nx3_r   <= nx2_r;
      nvy3_r  <= nvy2_r;
      n3_r    <= n2_r;
      keep3_r <= keep2_r;
      vydt3_r <= nvy2_r * dt_s;
    end
  end

  // stage 4: y position
  kin_res_t res4_r;
  logic signed [31:0] ny4_nxt;
  assign ny4_nxt = sat32(64'(py3_r) + 64'(vydt3_r >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      res4_r.nx   <= nx3_r;
      res4_r.ny   <= keep3_r ? ny4_nxt : py3_r;
      res4_r.nvx  <= vx3_r;
      res4_r.nvy  <= nvy3_r;
      res4_r.px   <= px3_r;
      res4_r.py   <= py3_r;
      res4_r.n    <= n3_r;
      res4_r.keep <= keep3_r;
    end
  end

  assign kin_res = res4_r;

endmodule
`default_nettype wire

// ===== sv/pgu_div.sv =====
// Pipelined restoring divider for the fade: floor(num * 2^FRAC_BITS / den),
// one quotient bit per stage. Depends on pgu_pkg.
`default_nettype none
module pgu_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  pgu_pkg::div_op_t op,
  output logic [16:0]      alpha
);
  import pgu_pkg::*;

  logic [30:0]    r_r    [DIV_STEPS];
  logic [Q_W-1:0] q_r    [DIV_STEPS];
  logic [30:0]    den_r  [DIV_STEPS];
  logic           zero_r [DIV_STEPS];
  logic [30:0]    r_nxt  [DIV_STEPS];
  logic [Q_W-1:0] q_nxt  [DIV_STEPS];

  always_comb begin
    logic [31:0] t;
    logic [30:0] dsrc;
    logic        ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        t    = {1'b0, op.num};
        dsrc = op.den;
      end else begin
        t    = {r_r[k-1], 1'b0};
        dsrc = den_r[k-1];
      end
      ge = t >= {1'b0, dsrc};
      r_nxt[k] = ge ? 31'(t - {1'b0, dsrc}) : t[30:0];
      if (k == 0) begin
        q_nxt[k] = Q_W'(ge);
      end else begin
        q_nxt[k] = {q_r[k-1][Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        r_r[k] <= r_nxt[k];
        q_r[k] <= q_nxt[k];
        if (k == 0) begin
          den_r[k]  <= op.den;
          zero_r[k] <= op.zero;
        end else begin
          den_r[k]  <= den_r[k-1];
          zero_r[k] <= zero_r[k-1];
        end
      end
    end
  end

  assign alpha = zero_r[DIV_STEPS-1] ? '0 : ALPHA_W'(q_r[DIV_STEPS-1]);

endmodule
`default_nettype wire
